>>> design/rbcm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the raster boundary cell marker
// no dependencies; imported by rbcm_ctrl, rbcm_judge and the core module

package rbcm_pkg;

    // default sizes
    localparam int DEF_MAX_LINE_CELLS = 1024;
    localparam int DEF_VALUE_BITS     = 32;

    // stream payload widths
    localparam int CELL_VALUE_W = 32;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CPL_W      = 11;
    localparam int LINE_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_LINE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_NEIGHBOURS = 2'd2;

    localparam int          CFG_CELLS_RESET = 1024;
    localparam int          CFG_LINES_RESET = 1024;
    localparam logic        CFG_EIGHT_RESET = 1'b1;

    // request kinds on s_tuser
    localparam logic REQ_CELL  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef enum logic
    {
        OP_STEP,
        OP_END
    } op_t;

    // control of the item held in the line store stage
    typedef struct packed
    {
        logic valid;
        op_t  op;
        logic writes;
        logic first_col;
        logic second_col;
        logic line_ge1;
        logic line_ge2;
        logic single_col;
        logic eight;
    } step_ctrl_t;

endpackage

>>> design/rbcm_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module rbcm_ram
#(
    parameter int DATA_W = 66,
    parameter int DEPTH  = 1024,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/rbcm_ctrl.sv
`timescale 1ns / 1ps
// configuration registers, scan position counters and issue stage
// depends on rbcm_pkg; drives the line store read port and the judge stage

module rbcm_ctrl
    import rbcm_pkg::*;
#(
    parameter int MAX_LINE_CELLS = DEF_MAX_LINE_CELLS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS,
    localparam int AW            = $clog2(MAX_LINE_CELLS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s1_ready,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    output step_ctrl_t            s1_ctrl,
    output logic [AW-1:0]         s1_addr,
    output logic [VALUE_BITS:0]   s1_cell
);

    localparam int CNT_W       = $clog2(MAX_LINE_CELLS + 1);
    localparam int CELLS_RESET = (CFG_CELLS_RESET > MAX_LINE_CELLS) ?
                                 MAX_LINE_CELLS : CFG_CELLS_RESET;

    logic [CNT_W-1:0]  cells_reg;
    logic [LINE_W-1:0] lines_reg;
    logic              eight_reg;
    logic [CNT_W-1:0]  cells_eff;
    logic [LINE_W-1:0] lines_eff;
    logic [CPL_W-1:0]  cells_raw;

    logic [CNT_W-1:0]  col_pos_reg, col_pos_next;
    logic [LINE_W-1:0] line_pos_reg, line_pos_next;
    logic              drain_reg, drain_next;
    logic              inject_reg, inject_next;

    step_ctrl_t        issue;
    step_ctrl_t        s1_ctrl_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [VALUE_BITS:0] s1_cell_reg;
    logic [VALUE_BITS:0] cell_in;

    logic accept;
    logic is_drain;
    logic col_wrap;
    logic line_final;
    logic col_end;

    assign cfg_ready = 1'b1;

    // register values are stored already clamped to their usable range
    always_comb
    begin
        cells_raw = cfg_data[CPL_W-1:0];
        if (cells_raw == '0)
            cells_eff = CNT_W'(1);
        else if (32'(cells_raw) > 32'(MAX_LINE_CELLS))
            cells_eff = CNT_W'(MAX_LINE_CELLS);
        else
            cells_eff = CNT_W'(cells_raw);
        lines_eff = (cfg_data == '0) ? LINE_W'(1) : cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= CNT_W'(CELLS_RESET);
            lines_reg <= LINE_W'(CFG_LINES_RESET);
            eight_reg <= CFG_EIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CELLS_PER_LINE:   cells_reg <= cells_eff;
                CFG_LINE_COUNT:       lines_reg <= lines_eff;
                CFG_EIGHT_NEIGHBOURS: eight_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign s_tready = s1_ready && !inject_reg;
    assign accept   = s_tvalid && s_tready;
    assign is_drain = (s_tuser[0] == REQ_DRAIN);

    assign cell_in  = s_tdata[0] ? {1'b1, {VALUE_BITS{1'b0}}}
                                 : {1'b0, s_tdata[VALUE_BITS:1]};

    assign col_wrap   = ({1'b0, col_pos_reg} + 1'b1) >= {1'b0, cells_reg};
    assign line_final = ({1'b0, line_pos_reg} + 1'b1) >= {1'b0, lines_reg};
    assign col_end    = col_pos_reg >= cells_reg;

    always_comb
    begin
        issue            = '0;
        issue.op         = OP_STEP;
        issue.first_col  = (col_pos_reg == '0);
        issue.second_col = (col_pos_reg == CNT_W'(1));
        issue.line_ge1   = (line_pos_reg != '0);
        issue.line_ge2   = (line_pos_reg[LINE_W-1:1] != '0);
        issue.single_col = (cells_reg == CNT_W'(1));
        issue.eight      = eight_reg;

        col_pos_next  = col_pos_reg;
        line_pos_next = line_pos_reg;
        drain_next    = drain_reg;
        inject_next   = inject_reg;

        // single-line raster: column zero of the tail is loaded without a result
        priority if (s1_ready && inject_reg)
        begin
            issue.valid  = 1'b1;
            col_pos_next = col_pos_reg + 1'b1;
            inject_next  = 1'b0;
        end
        else if (accept && !is_drain && !drain_reg)
        begin
            issue.valid  = 1'b1;
            issue.writes = 1'b1;
            if (col_wrap)
            begin
                col_pos_next  = '0;
                line_pos_next = line_pos_reg + 1'b1;
                if (line_final)
                begin
                    drain_next  = 1'b1;
                    inject_next = (line_pos_reg == '0);
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
        else if (accept && is_drain && drain_reg)
        begin
            issue.valid = 1'b1;
            if (col_end)
            begin
                issue.op      = OP_END;
                col_pos_next  = '0;
                line_pos_next = '0;
                drain_next    = 1'b0;
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
        else
        begin
            issue.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            line_pos_reg <= '0;
            drain_reg    <= 1'b0;
            inject_reg   <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            line_pos_reg <= line_pos_next;
            drain_reg    <= drain_next;
            inject_reg   <= inject_next;
            if (s1_ready)
            begin
                s1_ctrl_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_addr_reg <= col_pos_reg[AW-1:0];
            s1_cell_reg <= cell_in;
        end
    end

    assign rd_en   = s1_ready;
    assign rd_addr = col_pos_reg[AW-1:0];
    assign s1_ctrl = s1_ctrl_reg;
    assign s1_addr = s1_addr_reg;
    assign s1_cell = s1_cell_reg;

endmodule

>>> design/rbcm_judge.sv
`timescale 1ns / 1ps
// line store read-modify-write, 3x3 column window and boundary decision
// depends on rbcm_pkg; fed by rbcm_ctrl and the line store ram

module rbcm_judge
    import rbcm_pkg::*;
#(
    parameter int MAX_LINE_CELLS = DEF_MAX_LINE_CELLS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS,
    localparam int AW            = $clog2(MAX_LINE_CELLS),
    localparam int MEM_W         = 2 * (VALUE_BITS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  step_ctrl_t           s1_ctrl,
    input  logic [AW-1:0]        s1_addr,
    input  logic [VALUE_BITS:0]  s1_cell,
    input  logic [MEM_W-1:0]     rd_data,
    output logic                 s1_ready,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [MEM_W-1:0]     wr_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int CW = VALUE_BITS + 1;

    typedef struct packed
    {
        logic                  up_na;
        logic                  mid_na;
        logic [VALUE_BITS-1:0] mid_val;
        logic                  down_na;
    } col_t;

    // returns {boundary, missing}
    function automatic logic [1:0] judge_cell(input col_t l, input col_t m,
                                              input col_t r, input logic eight);
        logic bnd;
        bnd = (r.mid_na != m.mid_na) || (r.mid_val != m.mid_val) ||
              l.mid_na || m.up_na || m.down_na;
        if (eight)
            bnd = bnd || l.up_na || l.down_na || r.up_na || r.down_na;
        if (m.mid_na)
            return 2'b01;
        return {bnd, 1'b0};
    endfunction

    col_t win_b_reg, win_c_reg;
    col_t nc, end_left, step_left;

    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [MEM_W-1:0] fwd_data_reg;
    logic [MEM_W-1:0] entry;
    logic [CW-1:0]    prev_cell, cur_cell;

    logic             advance;
    logic             made;
    logic [1:0]       res;
    logic             res_last;
    logic [1:0]       end_res, step_res;
    logic             is_step;

    logic m_tvalid_reg, m_tvalid_next;
    logic m_missing_reg, m_boundary_reg, m_last_reg;

    assign advance  = s1_ctrl.valid && (!m_tvalid_reg || m_tready);
    assign s1_ready = !s1_ctrl.valid || advance;
    assign is_step  = s1_ctrl.valid && (s1_ctrl.op == OP_STEP);

    // the most recently written entry is not yet visible at the ram output
    assign entry     = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rd_data;
    assign prev_cell = entry[MEM_W-1 -: CW];
    assign cur_cell  = entry[CW-1:0];

    always_comb
    begin
        nc.up_na   = s1_ctrl.line_ge2 ? prev_cell[CW-1] : cur_cell[CW-1];
        nc.mid_na  = cur_cell[CW-1];
        nc.mid_val = cur_cell[VALUE_BITS-1:0];
        nc.down_na = s1_ctrl.writes ? s1_cell[CW-1] : cur_cell[CW-1];
    end

    assign end_left  = s1_ctrl.single_col ? win_c_reg : win_b_reg;
    assign step_left = s1_ctrl.second_col ? win_c_reg : win_b_reg;
    assign end_res   = judge_cell(end_left, win_c_reg, win_c_reg, s1_ctrl.eight);
    assign step_res  = judge_cell(step_left, win_c_reg, nc, s1_ctrl.eight);

    always_comb
    begin
        made     = 1'b0;
        res      = end_res;
        res_last = 1'b0;
        priority if (s1_ctrl.valid && s1_ctrl.op == OP_END)
        begin
            made     = 1'b1;
            res_last = 1'b1;
        end
        else if (is_step && s1_ctrl.first_col && s1_ctrl.line_ge2)
        begin
            made = 1'b1;
        end
        else if (is_step && !s1_ctrl.first_col && s1_ctrl.line_ge1)
        begin
            made = 1'b1;
            res  = step_res;
        end
        else
        begin
            made = 1'b0;
        end
    end

    assign wr_en   = advance && is_step && s1_ctrl.writes;
    assign wr_addr = s1_addr;
    assign wr_data = {cur_cell, s1_cell};

    always_comb
    begin
        if (advance)
            m_tvalid_next = made;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_b_reg     <= '0;
            win_c_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (advance && is_step)
            begin
                win_b_reg <= win_c_reg;
                win_c_reg <= nc;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (advance && made)
        begin
            m_missing_reg  <= res[0];
            m_boundary_reg <= res[1];
            m_last_reg     <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2){1'b0}}, m_boundary_reg, m_missing_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> design/raster_boundary_cell_marker_core.sv
`timescale 1ns / 1ps
// result path: issue register, then line store stage, then output register
// throughput: one item per clock unless m_tready stalls the output, set by the single
//   read-modify-write of one line store entry per item; a single-line raster holds
//   s_tready low at its end while column zero of the tail is loaded
// reset: asynchronous, clears counters, window and handshake state and loads register
//   defaults; the line store is not cleared and is read only where already written

module raster_boundary_cell_marker_core
    import rbcm_pkg::*;
#(
    parameter int MAX_LINE_CELLS = DEF_MAX_LINE_CELLS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // cell_missing, cell_value[31:0], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // out_missing, out_boundary, zero pad
    output logic                  m_tlast
);

    localparam int AW    = $clog2(MAX_LINE_CELLS);
    localparam int MEM_W = 2 * (VALUE_BITS + 1);

    step_ctrl_t          s1_ctrl;
    logic [AW-1:0]       s1_addr;
    logic [VALUE_BITS:0] s1_cell;
    logic                s1_ready;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [MEM_W-1:0]    rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MEM_W-1:0]    wr_data;

    rbcm_ctrl #(
        .MAX_LINE_CELLS (MAX_LINE_CELLS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s1_ready  (s1_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_ctrl   (s1_ctrl),
        .s1_addr   (s1_addr),
        .s1_cell   (s1_cell)
    );

    // one entry holds the previous line cell above the current line cell
    rbcm_ram #(
        .DATA_W (MEM_W),
        .DEPTH  (MAX_LINE_CELLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rbcm_judge #(
        .MAX_LINE_CELLS (MAX_LINE_CELLS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_judge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_ctrl  (s1_ctrl),
        .s1_addr  (s1_addr),
        .s1_cell  (s1_cell),
        .rd_data  (rd_data),
        .s1_ready (s1_ready),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/tb_raster_boundary_cell_marker_core.sv
`timescale 1ns / 1ps
// testbench for raster_boundary_cell_marker_core: streams rasters of class cells and drain
// requests under random stalls, predicts every boundary mark and checks each output transaction
// depends on rbcm_pkg and the core module only

module tb_raster_boundary_cell_marker_core;

    import rbcm_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 260;
    localparam int unsigned WIDE_TAIL     = 32;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned MAX_PRINTED   = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef bit [32:0] entry_t;  // bit 32 marks a missing cell

    typedef struct
    {
        entry_t up;
        entry_t mid;
        entry_t down;
    } column_t;

    typedef struct
    {
        bit missing;
        bit boundary;
        bit last;
    } mark_t;

    // tracks the raster position, line stores and 3x3 window, and the marks still due
    class edge_mark_tracker;
        bit [CPL_W-1:0]  cells_reg;
        bit [LINE_W-1:0] lines_reg;
        bit              eight_reg;
        entry_t          upper_line [DEF_MAX_LINE_CELLS];
        entry_t          recent_line [DEF_MAX_LINE_CELLS];
        int unsigned     col;
        int unsigned     row;
        int unsigned     drain_left;
        column_t         win_l;
        column_t         win_m;
        column_t         win_r;
        mark_t           pending_marks [$];
        int unsigned     n_cells;
        int unsigned     n_drains;
        int unsigned     n_ignored;
        int unsigned     n_checked;
        int unsigned     n_errors;
        int unsigned     n_printed;

        function new();
            cells_reg = CPL_W'(CFG_CELLS_RESET);
            lines_reg = LINE_W'(CFG_LINES_RESET);
            eight_reg = CFG_EIGHT_RESET;
        endfunction

        function int unsigned line_cells();
            if (cells_reg == 0)
                return 1;
            if (cells_reg > DEF_MAX_LINE_CELLS)
                return DEF_MAX_LINE_CELLS;
            return cells_reg;
        endfunction

        function int unsigned raster_lines();
            return (lines_reg == 0) ? 1 : lines_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CELLS_PER_LINE:   cells_reg = data[CPL_W-1:0];
                CFG_LINE_COUNT:       lines_reg = data[LINE_W-1:0];
                CFG_EIGHT_NEIGHBOURS: eight_reg = data[0];
                default: ;
            endcase
        endfunction

        function void classify(column_t l, column_t m, column_t r, bit last);
            mark_t mk;
            bit    b;
            mk.last = last;
            if (m.mid[32])
            begin
                mk.missing  = 1'b1;
                mk.boundary = 1'b0;
            end
            else
            begin
                b = (r.mid != m.mid) || l.mid[32] || m.up[32] || m.down[32];
                if (eight_reg)
                    b = b || l.up[32] || l.down[32] || r.up[32] || r.down[32];
                mk.missing  = 1'b0;
                mk.boundary = b;
            end
            pending_marks.push_back(mk);
        endfunction

        // last column of a line: its right neighbour is itself
        function void close_line(bit last);
            if (line_cells() == 1)
                classify(win_r, win_r, win_r, last);
            else
                classify(win_m, win_r, win_r, last);
        endfunction

        function bit shift_column(entry_t below, bit is_cell);
            int unsigned qi;
            column_t     nc;
            bit          made;
            qi   = (col < DEF_MAX_LINE_CELLS) ? col : DEF_MAX_LINE_CELLS - 1;
            made = 1'b0;
            if (col == 0 && row >= 2)
            begin
                close_line(1'b0);
                made = 1'b1;
            end
            nc.up   = (row >= 2) ? upper_line[qi] : recent_line[qi];
            nc.mid  = recent_line[qi];
            nc.down = is_cell ? below : recent_line[qi];
            if (is_cell)
            begin
                upper_line[qi]  = recent_line[qi];
                recent_line[qi] = below;
            end
            win_l = win_m;
            win_m = win_r;
            win_r = nc;
            if (col >= 1 && row >= 1)
            begin
                // first column of a line: left neighbour replicated from itself
                if (col == 1)
                    classify(win_m, win_m, win_r, 1'b0);
                else
                    classify(win_l, win_m, win_r, 1'b0);
                made = 1'b1;
            end
            return made;
        endfunction

        // returns 0 when the block ignores the item
        function bit take_item(logic req, logic missing, logic [31:0] value);
            entry_t px;
            bit     done;
            int     k;
            if (req == REQ_CELL)
            begin
                if (drain_left != 0)
                begin
                    n_ignored++;
                    return 1'b0;
                end
                px = missing ? 33'h1_0000_0000 : {1'b0, value};
                void'(shift_column(px, 1'b1));
                if (col + 1 >= line_cells())
                begin
                    done = (row + 1 >= raster_lines());
                    col  = 0;
                    row  = (row + 1) & 32'hFFFF;
                    if (done)
                        drain_left = line_cells() + ((row >= 2) ? 1 : 0);
                end
                else
                begin
                    col++;
                end
                n_cells++;
                return 1'b1;
            end
            if (drain_left == 0)
            begin
                n_ignored++;
                return 1'b0;
            end
            n_drains++;
            for (k = 0; k < 2; k++)
            begin
                if (col >= line_cells())
                begin
                    close_line(1'b1);
                    col        = 0;
                    row        = 0;
                    drain_left = 0;
                    return 1'b1;
                end
                if (shift_column('0, 1'b0))
                begin
                    col++;
                    if (drain_left > 1)
                        drain_left--;
                    return 1'b1;
                end
                col++;
            end
            return 1'b1;
        endfunction

        function void check_field(string name, bit want, logic got);
            if (got !== want)
            begin
                n_errors++;
                if (n_printed < MAX_PRINTED)
                begin
                    n_printed++;
                    $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name,
                             want, got);
                end
            end
        endfunction

        function void compare_mark(logic [M_TDATA_W-1:0] data, logic last);
            mark_t want;
            if (pending_marks.size() == 0)
            begin
                n_errors++;
                if (n_printed < MAX_PRINTED)
                begin
                    n_printed++;
                    $display("%0t ns: unexpected result, expected none, actual tdata %h tlast %0b",
                             $time, data, last);
                end
                return;
            end
            want = pending_marks.pop_front();
            n_checked++;
            check_field("out_missing", want.missing, data[0]);
            check_field("out_boundary", want.boundary, data[1]);
            check_field("out_last", want.last, last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;  // cell_missing, cell_value[31:0], zero pad
    logic [S_TUSER_W-1:0]  s_tuser;  // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;  // out_missing, out_boundary, zero pad
    logic                  m_tlast;

    edge_mark_tracker board;
    int unsigned      sender_idle;
    int unsigned      receiver_idle;
    int unsigned      stall_cycles;
    int unsigned      n_rasters;
    int unsigned      n_writes;

    raster_boundary_cell_marker_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.compare_mark(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input logic req, input logic missing, input logic [31:0] value);
        while ($urandom_range(99) < sender_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-CELL_VALUE_W-1){1'b0}}, value, missing};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        void'(board.take_item(req, missing, value));
    endtask

    // all marks delivered and the pipeline given time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_marks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        n_writes++;
    endtask

    task automatic program_raster(input int unsigned cells, input int unsigned lines,
                                  input bit eight);
        settle();
        write_reg(CFG_CELLS_PER_LINE, {(CFG_DATA_W-CPL_W)'($urandom), CPL_W'(cells)});
        write_reg(CFG_LINE_COUNT, CFG_DATA_W'(lines));
        write_reg(CFG_EIGHT_NEIGHBOURS, {(CFG_DATA_W-1)'($urandom), eight});
        cfg_valid <= 1'b0;
    endtask

    task automatic flush_raster(input int unsigned noise_pct);
        while (board.drain_left != 0)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(REQ_CELL, 1'($urandom_range(1)), $urandom);
            else
                send_item(REQ_DRAIN, 1'($urandom_range(1)), $urandom);
        end
        n_rasters++;
    endtask

    task automatic run_raster(input bit open_ended);
        logic [31:0] classes [3];
        int unsigned na_pct;
        int unsigned cut_at;
        int unsigned sent;
        logic        missing;
        logic [31:0] value;
        foreach (classes[i])
        begin
            case ($urandom_range(5))
                0:       classes[i] = 32'h7FFF_FFFF;
                1:       classes[i] = 32'h8000_0001;
                2:       classes[i] = $urandom;
                default: classes[i] = $urandom_range(9);
            endcase
        end
        na_pct = $urandom_range(35);
        cut_at = $urandom_range(1, 3 * board.line_cells());
        sent   = 0;
        while (board.drain_left == 0)
        begin
            // endless raster: shorten it from inside
            if (open_ended && sent == cut_at)
            begin
                settle();
                write_reg(CFG_LINE_COUNT, CFG_DATA_W'($urandom_range(board.row + 2)));
                write_reg(CFG_EIGHT_NEIGHBOURS, CFG_DATA_W'($urandom_range(1)));
                cfg_valid <= 1'b0;
            end
            if ($urandom_range(99) < 3)
                send_item(REQ_DRAIN, 1'($urandom_range(1)), $urandom);
            missing = ($urandom_range(99) < na_pct);
            value   = ($urandom_range(9) == 0) ? $urandom : classes[$urandom_range(2)];
            send_item(REQ_CELL, missing, value);
            sent++;
        end
        flush_raster(6);
    endtask

    initial
    begin
        int unsigned base;
        int unsigned done_items;
        int unsigned cells;
        int unsigned lines;
        bit          open_ended;

        board = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        sender_idle   = 12;
        receiver_idle = 76;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain with nothing pending, write to an unused index
        send_item(REQ_DRAIN, 1'b1, 32'hFFFF_FFFF);
        settle();
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        cfg_valid <= 1'b0;

        // 3-wide raster of the largest line count, cut short mid raster
        program_raster(3, 16'hFFFF, 1'b1);
        send_item(REQ_CELL, 1'b0, 32'd5);
        send_item(REQ_CELL, 1'b1, 32'd0);
        send_item(REQ_CELL, 1'b0, 32'h7FFF_FFFF);
        send_item(REQ_CELL, 1'b0, 32'h8000_0001);
        send_item(REQ_CELL, 1'b0, 32'h8000_0001);
        send_item(REQ_CELL, 1'b0, 32'd5);
        settle();
        write_reg(CFG_LINE_COUNT, '0);
        write_reg(CFG_EIGHT_NEIGHBOURS, '0);
        cfg_valid <= 1'b0;
        send_item(REQ_CELL, 1'b1, 32'hFFFF_FFFF);
        send_item(REQ_CELL, 1'b0, 32'd0);
        send_item(REQ_CELL, 1'b0, 32'd0);
        send_item(REQ_CELL, 1'b0, 32'h1234_5678);
        flush_raster(0);
        send_item(REQ_DRAIN, 1'b0, 32'd0);

        // zero line width acts as a single column
        program_raster(0, 2, 1'b0);
        send_item(REQ_CELL, 1'b1, 32'd0);
        send_item(REQ_CELL, 1'b0, 32'd7);
        flush_raster(0);

        base = board.n_cells + board.n_drains;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items < RANDOM_ITEMS / 3)
            begin
                sender_idle   = 12;
                receiver_idle = 76;
            end
            else if (done_items < 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle   = 76;
                receiver_idle = 12;
            end
            else
            begin
                sender_idle   = 0;
                receiver_idle = 0;
            end
            case ($urandom_range(15))
                0:       cells = 0;
                1:       cells = 1;
                2:       cells = $urandom_range(13, 48);
                default: cells = $urandom_range(2, 12);
            endcase
            lines      = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6);
            open_ended = ($urandom_range(7) == 0);
            if (open_ended)
                lines = $urandom_range(1) ? 65535 : $urandom_range(200, 65534);
            program_raster(cells, lines, 1'($urandom_range(1)));
            run_raster(open_ended);
            done_items = board.n_cells + board.n_drains - base;
        end

        // widest line, register value above the store depth; second line stops early
        program_raster(2047, 2, 1'($urandom_range(1)));
        repeat (DEF_MAX_LINE_CELLS + WIDE_TAIL)
            send_item(REQ_CELL, ($urandom_range(99) < 15), 32'($urandom_range(3)));

        s_tvalid <= 1'b0;
        while (board.pending_marks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("streamed %0d cells and %0d drains in %0d rasters, %0d ignored, %0d reg writes",
                 board.n_cells, board.n_drains, n_rasters, board.n_ignored, n_writes);
        $display("checked %0d marks, %0d mismatches", board.n_checked, board.n_errors);
        if (board.n_errors == 0 && board.pending_marks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
